// ===== hdl/utf8_terminal_line_editor_macros.svh =====
// Assertion helpers shared by the line editor RTL.
`ifndef UTF8_TERMINAL_LINE_EDITOR_MACROS_SVH
`define UTF8_TERMINAL_LINE_EDITOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UTLE_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define UTLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/utle_pkg.sv =====
package utle_pkg;

    typedef enum logic [1:0] {
        OP_FEED  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        EV_MORE = 2'd0,
        EV_EDIT = 2'd1,
        EV_ECHO = 2'd2,
        EV_DONE = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        ESC_NONE  = 2'd0,
        ESC_START = 2'd1,
        ESC_SEQ   = 2'd2
    } t_esc;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RDWAIT = 4'b0010,
        ST_ERASE  = 4'b0100,
        ST_PEND   = 4'b1000
    } t_state;

    localparam logic [7:0] CH_CTRL_C    = 8'h03;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_CTRL_U    = 8'h15;
    localparam logic [7:0] CH_ESC       = 8'h1B;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_FINAL_LO  = 8'h40;
    localparam logic [7:0] CH_SS3       = 8'h4F;
    localparam logic [7:0] CH_CSI       = 8'h5B;
    localparam logic [7:0] CH_FINAL_HI  = 8'h7E;
    localparam logic [7:0] CH_DEL       = 8'h7F;
    localparam logic [7:0] UTF8_TOP_MSK = 8'hC0;
    localparam logic [7:0] UTF8_CONT    = 8'h80;

    localparam logic [8:0] CAP_RESET    = 9'd256;

endpackage

// ===== hdl/utle_ram.sv =====
module utle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/utf8_terminal_line_editor.sv =====
// Terminal line editor: bytes go in one item at a time, the line is held in a
// one-port-write / one-port-read RAM of BUF_DEPTH bytes. An ordinary feed, a clear
// or an unknown opcode passes the accept stage, then the result stage (ST_PEND); a read
// goes through ST_RDWAIT for the RAM read latency before ST_PEND; a backspace that removes k
// bytes (trailing UTF-8 continuation bytes plus the lead byte) walks back through ST_ERASE,
// one RAM read per byte walked back, then ST_PEND. A new item is accepted while the last
// result still waits at the output register. The RAM needs no clearing pass.
module utf8_terminal_line_editor #(
    parameter int BUF_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [8:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_byte_in,
    input  logic [7:0] i_read_index,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_event_res,
    output logic [7:0] o_line_length,
    output logic       o_overflowed,
    output logic [7:0] o_read_byte
);

`include "utf8_terminal_line_editor_macros.svh"

    localparam int AW        = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CAP_LIMIT = (BUF_DEPTH < 256) ? BUF_DEPTH : 256;
    localparam logic [8:0] CAP_MAX = 9'(CAP_LIMIT);

    utle_pkg::t_state r_state, n_state;
    utle_pkg::t_esc   r_esc, n_esc;
    logic [7:0] r_len, n_len;
    logic       r_ovf, n_ovf;
    logic       r_fin, n_fin;
    logic       r_cr, n_cr;
    logic [8:0] r_cap;
    logic       r_rd_hit, n_rd_hit;
    logic [1:0] r_pend_event, n_pend_event;
    logic [7:0] r_pend_byte, n_pend_byte;
    logic       r_o_valid, n_o_valid;
    logic [1:0] r_o_event, n_o_event;
    logic [7:0] r_o_len, n_o_len;
    logic       r_o_ovf, n_o_ovf;
    logic [7:0] r_o_byte, n_o_byte;

    logic          in_accept;
    logic [8:0]    eff_cap;
    logic [7:0]    base_len;
    logic          base_ovf;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == utle_pkg::ST_IDLE);
    assign in_accept   = i_in_valid && (r_state == utle_pkg::ST_IDLE);
    assign eff_cap     = (r_cap > CAP_MAX) ? CAP_MAX : r_cap;
    // a finished line is dropped by the next fed byte
    assign base_len    = r_fin ? 8'd0 : r_len;
    assign base_ovf    = r_fin ? 1'b0 : r_ovf;
    assign ram_waddr   = AW'(base_len);

    // Writes happen only on feed accept; the next RAM read that is used is issued at a later
    // accept, after ST_PEND, so there is no read/write overlap on one entry.
    utle_ram #(
        .WIDTH(8),
        .DEPTH(BUF_DEPTH)
    ) u_line_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_byte_in),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_esc        = r_esc;
        n_len        = r_len;
        n_ovf        = r_ovf;
        n_fin        = r_fin;
        n_cr         = r_cr;
        n_rd_hit     = r_rd_hit;
        n_pend_event = r_pend_event;
        n_pend_byte  = r_pend_byte;
        ram_we       = 1'b0;
        ram_raddr    = AW'(base_len - 8'd1);

        unique case (r_state)
            utle_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state      = utle_pkg::ST_PEND;
                    n_pend_event = utle_pkg::EV_MORE;
                    n_pend_byte  = 8'd0;
                    unique case (i_opcode)
                        utle_pkg::OP_FEED: begin
                            n_fin = 1'b0;
                            n_len = base_len;
                            n_ovf = base_ovf;
                            if (r_esc == utle_pkg::ESC_START) begin
                                n_esc = (i_byte_in == utle_pkg::CH_CSI ||
                                         i_byte_in == utle_pkg::CH_SS3) ?
                                        utle_pkg::ESC_SEQ : utle_pkg::ESC_NONE;
                            end else if (r_esc != utle_pkg::ESC_NONE) begin
                                if (i_byte_in >= utle_pkg::CH_FINAL_LO &&
                                    i_byte_in <= utle_pkg::CH_FINAL_HI) begin
                                    n_esc = utle_pkg::ESC_NONE;
                                end
                            end else if (i_byte_in == utle_pkg::CH_ESC) begin
                                n_esc = utle_pkg::ESC_START;
                                n_cr  = 1'b0;
                            end else if (i_byte_in == utle_pkg::CH_CR) begin
                                n_cr         = 1'b1;
                                n_fin        = 1'b1;
                                n_pend_event = utle_pkg::EV_DONE;
                            end else if (i_byte_in == utle_pkg::CH_LF) begin
                                if (r_cr) begin
                                    n_cr = 1'b0;
                                end else begin
                                    n_fin        = 1'b1;
                                    n_pend_event = utle_pkg::EV_DONE;
                                end
                            end else begin
                                n_cr = 1'b0;
                                if (i_byte_in == utle_pkg::CH_BS ||
                                    i_byte_in == utle_pkg::CH_DEL) begin
                                    if (base_len != 8'd0) begin
                                        // read of the last byte is issued now
                                        n_pend_event = utle_pkg::EV_EDIT;
                                        n_state      = utle_pkg::ST_ERASE;
                                    end
                                end else if (i_byte_in == utle_pkg::CH_CTRL_C ||
                                             i_byte_in == utle_pkg::CH_CTRL_U) begin
                                    if (base_len != 8'd0 || base_ovf) begin
                                        n_len        = 8'd0;
                                        n_ovf        = 1'b0;
                                        n_pend_event = utle_pkg::EV_EDIT;
                                    end
                                end else if (i_byte_in < utle_pkg::CH_SPACE) begin
                                    n_pend_event = utle_pkg::EV_MORE;
                                end else if ({1'b0, base_len} + 9'd1 >= eff_cap) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    ram_we       = 1'b1;
                                    n_len        = base_len + 8'd1;
                                    n_pend_event = utle_pkg::EV_ECHO;
                                end
                            end
                        end
                        utle_pkg::OP_READ: begin
                            ram_raddr = AW'(i_read_index);
                            n_rd_hit  = (i_read_index < r_len);
                            n_state   = utle_pkg::ST_RDWAIT;
                        end
                        utle_pkg::OP_CLEAR: begin
                            n_len = 8'd0;
                            n_ovf = 1'b0;
                            n_fin = 1'b0;
                            n_esc = utle_pkg::ESC_NONE;
                            n_cr  = 1'b0;
                        end
                        default: begin
                            n_pend_event = utle_pkg::EV_MORE;
                        end
                    endcase
                end
            end
            utle_pkg::ST_RDWAIT: begin
                n_pend_byte = r_rd_hit ? ram_rdata : 8'd0;
                n_state     = utle_pkg::ST_PEND;
            end
            utle_pkg::ST_ERASE: begin
                // ram_rdata is the byte at r_len-1; prefetch r_len-2 meanwhile
                ram_raddr = AW'(r_len - 8'd2);
                n_len     = r_len - 8'd1;
                if ((ram_rdata & utle_pkg::UTF8_TOP_MSK) == utle_pkg::UTF8_CONT) begin
                    if (r_len == 8'd1) begin
                        n_state = utle_pkg::ST_PEND;
                    end
                end else begin
                    n_state = utle_pkg::ST_PEND;
                end
            end
            utle_pkg::ST_PEND: begin
                if (!r_o_valid || i_out_ready) begin
                    n_state = utle_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = utle_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_o_valid = r_o_valid && !i_out_ready;
        n_o_event = r_o_event;
        n_o_len   = r_o_len;
        n_o_ovf   = r_o_ovf;
        n_o_byte  = r_o_byte;
        if (r_state == utle_pkg::ST_PEND && (!r_o_valid || i_out_ready)) begin
            n_o_valid = 1'b1;
            n_o_event = r_pend_event;
            n_o_len   = r_len;
            n_o_ovf   = r_ovf;
            n_o_byte  = r_pend_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= utle_pkg::ST_IDLE;
            r_esc     <= utle_pkg::ESC_NONE;
            r_len     <= 8'd0;
            r_ovf     <= 1'b0;
            r_fin     <= 1'b0;
            r_cr      <= 1'b0;
            r_cap     <= utle_pkg::CAP_RESET;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_esc     <= n_esc;
            r_len     <= n_len;
            r_ovf     <= n_ovf;
            r_fin     <= n_fin;
            r_cr      <= n_cr;
            r_o_valid <= n_o_valid;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_hit     <= n_rd_hit;
        r_pend_event <= n_pend_event;
        r_pend_byte  <= n_pend_byte;
        r_o_event    <= n_o_event;
        r_o_len      <= n_o_len;
        r_o_ovf      <= n_o_ovf;
        r_o_byte     <= n_o_byte;
    end

    assign o_out_valid   = r_o_valid;
    assign o_event_res   = r_o_event;
    assign o_line_length = r_o_len;
    assign o_overflowed  = r_o_ovf;
    assign o_read_byte   = r_o_byte;

    `UTLE_ASSERT(a_len_in_buffer, i_clk, i_rst_n, 1'b1, {1'b0, r_len} < CAP_MAX,
        "line length reached buffer limit")
    `UTLE_ASSERT(a_erase_nonempty, i_clk, i_rst_n, r_state == utle_pkg::ST_ERASE,
        r_len != 8'd0, "erase walk on empty line")
    `UTLE_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, in_accept,
        r_state != utle_pkg::ST_IDLE, "accepted item did not start work")
    `UTLE_ASSERT(a_write_only_on_feed, i_clk, i_rst_n, ram_we,
        in_accept && i_opcode == utle_pkg::OP_FEED, "buffer write outside a feed")

endmodule
